>>> rtl/power_window_controller_defines.svh
// Assertion macros for the power window controller checker.
// Used by pwc_checker; expects clk and rst in scope at the point of use.
`ifndef POWER_WINDOW_CONTROLLER_DEFINES_SVH
`define POWER_WINDOW_CONTROLLER_DEFINES_SVH

// checked outside reset
`define PWC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked through reset as well
`define PWC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/pwc_pkg.sv
// Shared types and constants for the power window controller.
// No dependencies; used by every other file but the defines header through scoped names.
package pwc_pkg;

  localparam int WINDOW_COUNT = 4;
  localparam int WIN_W        = 2;
  localparam int TIMER_W      = 16;
  localparam int CFG_IDX_W    = 1;

  localparam logic [TIMER_W-1:0] HOLD_TICKS_RESET = 16'd200;
  localparam logic [TIMER_W-1:0] JAM_TICKS_RESET  = 16'd1000;

  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS        = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_JAM_REVERSE_TICKS = 1'd1;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_HOLD_UP  = 3'd1,
    MODE_HOLD_DN  = 3'd2,
    MODE_MAN_UP   = 3'd3,
    MODE_MAN_DN   = 3'd4,
    MODE_AUTO_UP  = 3'd5,
    MODE_AUTO_DN  = 3'd6,
    MODE_JAM      = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    DRV_OFF = 2'd0,
    DRV_UP  = 2'd1,
    DRV_DN  = 2'd2
  } drive_t;

  typedef struct packed {
    mode_t              mode;
    logic [TIMER_W-1:0] timer;
    drive_t             motor;
  } win_state_t;

  // input transfer fields other than the window index, highest bit first
  typedef struct packed {
    logic jam_event;
    logic bottom_limit;
    logic top_limit;
    logic driver_down;
    logic driver_up;
    logic passenger_down;
    logic passenger_up;
    logic lock_toggle;
  } sample_t;

endpackage

>>> rtl/pwc_next.sv
// Next-state logic for one window: mode, tick timer and motor drive.
// Depends on pwc_pkg.
module pwc_next (
  input  pwc_pkg::win_state_t          cur,
  input  pwc_pkg::sample_t             smp,
  input  logic                         locked,
  input  logic [pwc_pkg::TIMER_W-1:0]  hold_ticks,
  input  logic [pwc_pkg::TIMER_W-1:0]  jam_reverse_ticks,
  output pwc_pkg::win_state_t          nxt
);

  logic                        up_req;
  logic                        dn_req;
  logic                        expired;
  logic [pwc_pkg::TIMER_W-1:0] timer_dec;

  assign up_req = ((smp.passenger_up && !locked) || smp.driver_up) && !smp.top_limit;
  assign dn_req = ((smp.passenger_down && !locked) || smp.driver_down) && !smp.bottom_limit;

  assign expired   = (cur.timer <= pwc_pkg::TIMER_W'(1));
  assign timer_dec = expired ? '0 : cur.timer - pwc_pkg::TIMER_W'(1);

  always_comb begin
    nxt = cur;
    unique case (cur.mode)
      pwc_pkg::MODE_IDLE: begin
        nxt.motor = pwc_pkg::DRV_OFF;
        if (up_req) begin
          nxt.timer = hold_ticks;
          nxt.mode  = pwc_pkg::MODE_HOLD_UP;
        end else if (dn_req) begin
          nxt.timer = hold_ticks;
          nxt.mode  = pwc_pkg::MODE_HOLD_DN;
        end
      end
      pwc_pkg::MODE_HOLD_UP: begin
        nxt.timer = timer_dec;
        if (expired) begin
          if (up_req) begin
            nxt.mode  = pwc_pkg::MODE_MAN_UP;
            nxt.motor = pwc_pkg::DRV_UP;
          end else if (!smp.top_limit) begin
            nxt.mode  = pwc_pkg::MODE_AUTO_UP;
            nxt.motor = pwc_pkg::DRV_UP;
          end else begin
            nxt.mode  = pwc_pkg::MODE_IDLE;
            nxt.motor = pwc_pkg::DRV_OFF;
          end
        end
      end
      pwc_pkg::MODE_HOLD_DN: begin
        nxt.timer = timer_dec;
        if (expired) begin
          if (dn_req) begin
            nxt.mode  = pwc_pkg::MODE_MAN_DN;
            nxt.motor = pwc_pkg::DRV_DN;
          end else if (!smp.bottom_limit) begin
            nxt.mode  = pwc_pkg::MODE_AUTO_DN;
            nxt.motor = pwc_pkg::DRV_DN;
          end else begin
            nxt.mode  = pwc_pkg::MODE_IDLE;
            nxt.motor = pwc_pkg::DRV_OFF;
          end
        end
      end
      pwc_pkg::MODE_MAN_UP: begin
        nxt.mode  = up_req ? pwc_pkg::MODE_MAN_UP : pwc_pkg::MODE_IDLE;
        nxt.motor = up_req ? pwc_pkg::DRV_UP : pwc_pkg::DRV_OFF;
      end
      pwc_pkg::MODE_MAN_DN: begin
        nxt.mode  = dn_req ? pwc_pkg::MODE_MAN_DN : pwc_pkg::MODE_IDLE;
        nxt.motor = dn_req ? pwc_pkg::DRV_DN : pwc_pkg::DRV_OFF;
      end
      pwc_pkg::MODE_AUTO_UP: begin
        priority if (smp.jam_event && smp.bottom_limit) begin
          nxt.mode  = pwc_pkg::MODE_IDLE;
          nxt.motor = pwc_pkg::DRV_OFF;
        end else if (smp.jam_event) begin
          nxt.timer = jam_reverse_ticks;
          nxt.mode  = pwc_pkg::MODE_JAM;
          nxt.motor = pwc_pkg::DRV_DN;
        end else if (smp.top_limit) begin
          nxt.mode  = pwc_pkg::MODE_IDLE;
          nxt.motor = pwc_pkg::DRV_OFF;
        end else begin
          nxt.motor = pwc_pkg::DRV_UP;
        end
      end
      pwc_pkg::MODE_AUTO_DN: begin
        nxt.mode  = smp.bottom_limit ? pwc_pkg::MODE_IDLE : pwc_pkg::MODE_AUTO_DN;
        nxt.motor = smp.bottom_limit ? pwc_pkg::DRV_OFF : pwc_pkg::DRV_DN;
      end
      pwc_pkg::MODE_JAM: begin
        if (smp.bottom_limit || expired) begin
          nxt.timer = '0;
          nxt.mode  = pwc_pkg::MODE_IDLE;
          nxt.motor = pwc_pkg::DRV_OFF;
        end else begin
          nxt.timer = timer_dec;
          nxt.motor = pwc_pkg::DRV_DN;
        end
      end
    endcase
  end

endmodule

>>> rtl/power_window_controller.sv
// Power window controller top level: input register, window state, result register.
// Depends on pwc_pkg and pwc_next.
//
//   channel  direction  payload                                   transfer when
//   s_*      in         tuser window, tdata switches/limits/jam   s_tvalid & s_tready
//   m_*      out        tuser window, tdata drive/mode/lock       m_tvalid & m_tready
//   cfg_*    in         cfg_index, cfg_data                       cfg_valid & cfg_ready
//
// One item per cycle unless m_tready stalls; items pass the input, then the result register.
// Window state is read, updated and written back in the cycle the item leaves
// the input register, so consecutive items on one window see each other.
// A stall on m_tready holds the result register and, once it is full, the input
// register; rst is synchronous and returns every window to idle, unlocked, with
// the register reset values.
module power_window_controller (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,  // lock_toggle, passenger_up,
                                                     // passenger_down, driver_up, driver_down,
                                                     // top_limit, bottom_limit, jam_event
  input  logic [pwc_pkg::WIN_W-1:0]        s_tuser,  // window_index
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [7:0]                       m_tdata,  // motor_drive[1:0], mode_out[4:2],
                                                     // locked_out[5], zero fill
  output logic [pwc_pkg::WIN_W-1:0]        m_tuser,  // window_out
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pwc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pwc_pkg::TIMER_W-1:0]      cfg_data
);

  logic [pwc_pkg::TIMER_W-1:0] hold_ticks;
  logic [pwc_pkg::TIMER_W-1:0] jam_reverse_ticks;

  logic                        s1_valid;
  pwc_pkg::sample_t            s1_smp;
  logic [pwc_pkg::WIN_W-1:0]   s1_win;

  pwc_pkg::win_state_t         win_st [pwc_pkg::WINDOW_COUNT];
  logic                        lock;

  pwc_pkg::win_state_t         cur;
  pwc_pkg::win_state_t         nxt;
  logic                        lock_next;
  logic                        win_ok;
  logic                        adv;
  logic                        fire;

  pwc_pkg::mode_t              out_mode;
  pwc_pkg::drive_t             out_motor;
  logic                        out_locked;

  assign cfg_ready = 1'b1;
  assign adv       = !m_tvalid || m_tready;
  assign fire      = s1_valid && adv;
  assign s_tready  = !s1_valid || adv;

  assign win_ok    = (32'(s1_win) < pwc_pkg::WINDOW_COUNT);
  assign cur       = win_st[s1_win];
  assign lock_next = lock ^ s1_smp.lock_toggle;

  pwc_next u_next (
    .cur               (cur),
    .smp               (s1_smp),
    .locked            (lock_next),
    .hold_ticks        (hold_ticks),
    .jam_reverse_ticks (jam_reverse_ticks),
    .nxt               (nxt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ticks        <= pwc_pkg::HOLD_TICKS_RESET;
      jam_reverse_ticks <= pwc_pkg::JAM_TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pwc_pkg::CFG_HOLD_TICKS:        hold_ticks        <= cfg_data;
        pwc_pkg::CFG_JAM_REVERSE_TICKS: jam_reverse_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      s1_smp <= pwc_pkg::sample_t'(s_tdata);
      s1_win <= s_tuser;
    end
  end

  // window state and lock
  always_ff @(posedge clk) begin
    if (rst) begin
      lock <= 1'b0;
      for (int i = 0; i < pwc_pkg::WINDOW_COUNT; i++) begin
        win_st[i].mode  <= pwc_pkg::MODE_IDLE;
        win_st[i].timer <= '0;
        win_st[i].motor <= pwc_pkg::DRV_OFF;
      end
    end else if (fire) begin
      lock <= lock_next;
      if (win_ok) begin
        win_st[s1_win] <= nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= s1_valid;
    end
    if (fire) begin
      m_tuser    <= s1_win;
      out_locked <= lock_next;
      out_mode   <= win_ok ? nxt.mode : pwc_pkg::MODE_IDLE;
      out_motor  <= win_ok ? nxt.motor : pwc_pkg::DRV_OFF;
    end
  end

  assign m_tdata = {2'b00, out_locked, out_mode, out_motor};

endmodule

>>> rtl/pwc_checker.sv
// Port-level checks for the power window controller, bound to the top level.
// Depends on pwc_pkg and power_window_controller_defines.svh.
`include "power_window_controller_defines.svh"

module pwc_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [7:0]                       m_tdata,
  input logic [pwc_pkg::WIN_W-1:0]        m_tuser
);

  logic drv_off;
  logic drv_up;
  logic drv_dn;
  logic mode_still;
  logic mode_up;
  logic drv_ok;
  logic stalled;
  logic [pwc_pkg::WIN_W+7:0] m_word;

  assign drv_off    = (m_tdata[1:0] == pwc_pkg::DRV_OFF);
  assign drv_up     = (m_tdata[1:0] == pwc_pkg::DRV_UP);
  assign drv_dn     = (m_tdata[1:0] == pwc_pkg::DRV_DN);
  assign mode_still = (m_tdata[4:2] == pwc_pkg::MODE_IDLE) ||
                      (m_tdata[4:2] == pwc_pkg::MODE_HOLD_UP) ||
                      (m_tdata[4:2] == pwc_pkg::MODE_HOLD_DN);
  assign mode_up    = (m_tdata[4:2] == pwc_pkg::MODE_MAN_UP) ||
                      (m_tdata[4:2] == pwc_pkg::MODE_AUTO_UP);
  assign drv_ok     = mode_still ? drv_off : (mode_up ? drv_up : drv_dn);
  assign stalled    = m_tvalid && !m_tready;
  assign m_word     = {m_tuser, m_tdata};

  `PWC_ASSERT(a_stall_hold, stalled |=> m_tvalid && $stable(m_word), "result changed under stall")

  `PWC_ASSERT(a_drive_mode, m_tvalid |-> drv_ok, "motor drive disagrees with mode")

  `PWC_ASSERT(a_pad_zero, m_tvalid |-> (m_tdata[7:6] == 2'b00), "result fill bits not zero")

  `PWC_ASSERT_ALWAYS(a_rst_empty, rst |=> !m_tvalid, "result valid straight after reset")

endmodule

bind power_window_controller pwc_checker u_pwc_checker (.*);
